// ===== hw/rtl/quadratic_root_solver_macros.svh =====
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define QRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qrs_pkg.sv =====
// Shared widths, codes and pipeline payload types for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    localparam int COEF_W     = 16;
    localparam int RAD_W      = 50;
    localparam int ROOT_W     = 25;
    localparam int REM_W      = 27;
    localparam int SQ_STAGES  = 25;
    localparam int NB_W       = 25;
    localparam int NUM_W      = 27;
    localparam int QM_W       = 33;
    localparam int DEN_W      = 16;
    localparam int DIV_STAGES = 33;
    localparam int VAL_W      = 32;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_DEGEN   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [NB_W-1:0]   nb;
        logic              a_neg;
        logic [DEN_W-1:0]  a_mag;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        side_t             side;
    } fr_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        side_t             side;
    } sq_t;

    typedef struct packed {
        kind_t             kind;
        logic [VAL_W-1:0]  first;
        logic [VAL_W-1:0]  second;
        logic              ovf;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/quadratic_root_solver.sv =====
// Top level of the pipelined quadratic root solver.
//
//  channel  dir  tdata (low bit up)                              tuser
//  s_*      in   coef_a[15:0] coef_b[31:16] coef_c[47:32]        -
//  m_*      out  first_value[31:0] second_value[63:32]           root_kind[1:0]
//                overflow[64], zero fill [71:65]
//
//  One transfer accepted per cycle while the pipeline is not full and stalled; the stages are
//  2 product/discriminant, 25 square-root bit stages, 1 numerator setup, 33 divider bit stages, 1 saturate.
//  The square-root bit chain and the 33-bit divider chain set the depth.
//  rst_n clears all stage valid bits asynchronously; payload is not reset.
//  Each stage holds while the next is full and stalled; bubbles collapse.
`timescale 1ns / 1ps
`default_nettype none

`include "quadratic_root_solver_macros.svh"

module quadratic_root_solver
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // coef_a, coef_b, coef_c
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,   // first_value, second_value, overflow, zero fill
    output logic [1:0]        m_tuser    // root_kind
);

    logic              fr_vld;
    logic              fr_rdy;
    qrs_pkg::fr_t      fr_data;
    logic              sq_vld;
    logic              sq_rdy;
    qrs_pkg::sq_t      sq_data;
    qrs_pkg::result_t  res;

    qrs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .coef_a    ($signed(s_tdata[15:0])),
        .coef_b    ($signed(s_tdata[31:16])),
        .coef_c    ($signed(s_tdata[47:32])),
        .out_valid (fr_vld),
        .out_ready (fr_rdy),
        .out_data  (fr_data)
    );

    qrs_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_vld),
        .in_ready  (fr_rdy),
        .in_data   (fr_data),
        .out_valid (sq_vld),
        .out_ready (sq_rdy),
        .out_data  (sq_data)
    );

    qrs_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .in_ready  (sq_rdy),
        .in_data   (sq_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {7'b0, res.ovf, res.second, res.first};
    assign m_tuser = res.kind;

    `QRS_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser == qrs_pkg::KIND_DEGEN, m_tdata == '0, "degenerate result carries nonzero values")
    `QRS_ASSERT_IMP(a_double_same, m_tvalid && m_tuser == qrs_pkg::KIND_DOUBLE, m_tdata[31:0] == m_tdata[63:32], "double root values differ")
    `QRS_ASSERT_IMP(a_imag_pos, m_tvalid && m_tuser == qrs_pkg::KIND_COMPLEX, !m_tdata[63], "imaginary magnitude negative")
    `QRS_ASSERT_IMP(a_stall_src, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")
    `QRS_ASSERT_NXT(a_enter_front, s_tvalid && s_tready, u_front.in_ready || fr_vld, "accepted transfer lost at entry")

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_front.sv =====
// Product and discriminant stages: forms b*b and a*c, then D, its magnitude and the root kind.
`timescale 1ns / 1ps
`default_nettype none

module qrs_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [qrs_pkg::COEF_W-1:0]   coef_a,
    input  wire logic signed [qrs_pkg::COEF_W-1:0]   coef_b,
    input  wire logic signed [qrs_pkg::COEF_W-1:0]   coef_c,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output qrs_pkg::fr_t                             out_data
);

    logic                                 vld0_reg;
    logic                                 vld1_reg;
    logic signed [qrs_pkg::COEF_W-1:0]    a0_reg;
    logic signed [qrs_pkg::COEF_W-1:0]    b0_reg;
    logic signed [31:0]                   bb_reg;
    logic signed [31:0]                   ac_reg;
    logic signed [31:0]                   bb_next;
    logic signed [31:0]                   ac_next;
    qrs_pkg::fr_t                         out_reg;
    qrs_pkg::fr_t                         out_next;
    logic                                 rdy0;
    logic                                 rdy1;
    logic signed [34:0]                   disc;
    logic [34:0]                          mag_w;

    assign rdy1     = !vld1_reg || out_ready;
    assign rdy0     = !vld0_reg || rdy1;
    assign in_ready = rdy0;

    always_comb
    begin
        bb_next = 32'(coef_b) * 32'(coef_b);
        ac_next = 32'(coef_a) * 32'(coef_c);
    end

    always_comb
    begin
        disc  = 35'(bb_reg) - (35'(ac_reg) <<< 2);
        mag_w = disc[34] ? 35'(-disc) : disc;
        out_next.rad        = {1'b0, mag_w[32:0], 16'b0};
        out_next.side.nb    = qrs_pkg::NB_W'(-(25'(b0_reg) <<< 8));
        out_next.side.a_neg = a0_reg[15];
        out_next.side.a_mag = a0_reg[15] ? 16'(-a0_reg) : a0_reg;
        if (a0_reg == '0)
        begin
            out_next.side.kind = qrs_pkg::KIND_DEGEN;
        end
        else if (disc == '0)
        begin
            out_next.side.kind = qrs_pkg::KIND_DOUBLE;
        end
        else if (disc[34])
        begin
            out_next.side.kind = qrs_pkg::KIND_COMPLEX;
        end
        else
        begin
            out_next.side.kind = qrs_pkg::KIND_REAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                vld0_reg <= in_valid;
            end
            if (rdy1)
            begin
                vld1_reg <= vld0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            a0_reg <= coef_a;
            b0_reg <= coef_b;
            bb_reg <= bb_next;
            ac_reg <= ac_next;
        end
        if (rdy1 && vld0_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = vld1_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire qrs_pkg::fr_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output qrs_pkg::sq_t       out_data
);

    localparam int N = qrs_pkg::SQ_STAGES;

    typedef struct packed {
        logic [qrs_pkg::RAD_W-1:0]  rad;
        logic [qrs_pkg::REM_W-1:0]  rem;
        logic [qrs_pkg::ROOT_W-1:0] root;
        qrs_pkg::side_t             side;
    } stg_t;

    stg_t       stg_reg [N];
    stg_t       stg_next [N];
    logic [N-1:0] vld_reg;
    logic [N-1:0] rdy;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        stg_t                         src;
        logic                         src_vld;
        logic [qrs_pkg::REM_W+1:0]    t;
        logic [qrs_pkg::REM_W+1:0]    trial;

        if (k == 0)
        begin : g_first
            assign src.rad  = in_data.rad;
            assign src.rem  = '0;
            assign src.root = '0;
            assign src.side = in_data.side;
            assign src_vld  = in_valid;
        end
        else
        begin : g_rest
            assign src     = stg_reg[k-1];
            assign src_vld = vld_reg[k-1];
        end

        if (k == N-1)
        begin : g_last
            assign rdy[k] = !vld_reg[k] || out_ready;
        end
        else
        begin : g_mid
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end

        always_comb
        begin
            t     = {src.rem, src.rad[qrs_pkg::RAD_W-1 -: 2]};
            trial = {2'b00, src.root, 2'b01};
            stg_next[k].rad  = {src.rad[qrs_pkg::RAD_W-3:0], 2'b00};
            stg_next[k].side = src.side;
            if (t >= trial)
            begin
                stg_next[k].rem  = qrs_pkg::REM_W'(t - trial);
                stg_next[k].root = {src.root[qrs_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                stg_next[k].rem  = qrs_pkg::REM_W'(t);
                stg_next[k].root = {src.root[qrs_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_vld)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign in_ready      = rdy[0];
    assign out_valid     = vld_reg[N-1];
    assign out_data.root = stg_reg[N-1].root;
    assign out_data.side = stg_reg[N-1].side;

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_div.sv =====
// Numerator setup, two-lane pipelined restoring divider and Q16.16 saturation.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire qrs_pkg::sq_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output qrs_pkg::result_t   out_data
);

    localparam int N  = qrs_pkg::DIV_STAGES;
    localparam int QW = qrs_pkg::QM_W;
    localparam int DW = qrs_pkg::DEN_W;
    localparam int NW = qrs_pkg::NUM_W;

    typedef struct packed {
        logic [DW-1:0]   rem1;
        logic [QW-1:0]   dq1;
        logic [DW-1:0]   rem2;
        logic [QW-1:0]   dq2;
        logic [DW-1:0]   den;
        logic            neg1;
        logic            neg2;
        qrs_pkg::kind_t  kind;
    } dv_t;

    function automatic logic [QW-1:0] sat_q(logic [QW-1:0] q, logic neg);
        logic [QW-1:0] r;
        if (!neg)
        begin
            if (q > QW'(32'h7FFF_FFFF))
            begin
                r = {1'b1, 32'h7FFF_FFFF};
            end
            else
            begin
                r = {1'b0, q[31:0]};
            end
        end
        else
        begin
            if (q > QW'(32'h8000_0000))
            begin
                r = {1'b1, 32'h8000_0000};
            end
            else
            begin
                r = {1'b0, 32'(QW'(0) - q)};
            end
        end
        return r;
    endfunction

    dv_t               prep_reg;
    dv_t               prep_next;
    logic              vldp_reg;
    logic              rdyp;
    dv_t               stg_reg [N];
    logic [N-1:0]      vld_reg;
    logic [N-1:0]      rdy;
    qrs_pkg::result_t  res_reg;
    qrs_pkg::result_t  res_next;
    logic              vldf_reg;
    logic              rdyf;

    logic signed [NW-1:0] nb27;
    logic signed [NW-1:0] s27;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic [NW-1:0]        abs1;
    logic [NW-1:0]        abs2;
    logic                 is_real;
    logic                 is_cplx;

    always_comb
    begin
        is_real = (in_data.side.kind == qrs_pkg::KIND_REAL);
        is_cplx = (in_data.side.kind == qrs_pkg::KIND_COMPLEX);
        nb27    = NW'($signed(in_data.side.nb));
        s27     = $signed({2'b00, in_data.root});
        n1      = is_real ? NW'(nb27 + s27) : nb27;
        if (is_real)
        begin
            n2 = NW'(nb27 - s27);
        end
        else if (is_cplx)
        begin
            n2 = s27;
        end
        else
        begin
            n2 = nb27;
        end
        abs1 = n1[NW-1] ? NW'(-n1) : n1;
        abs2 = n2[NW-1] ? NW'(-n2) : n2;
        prep_next.rem1 = '0;
        prep_next.rem2 = '0;
        prep_next.dq1  = {abs1[NW-2:0], 7'b0};
        prep_next.dq2  = {abs2[NW-2:0], 7'b0};
        prep_next.den  = (in_data.side.kind == qrs_pkg::KIND_DEGEN) ? DW'(1)
                                                                   : in_data.side.a_mag;
        prep_next.neg1 = n1[NW-1] ^ in_data.side.a_neg;
        prep_next.neg2 = is_cplx ? 1'b0 : (n2[NW-1] ^ in_data.side.a_neg);
        prep_next.kind = in_data.side.kind;
    end

    assign rdyp     = !vldp_reg || rdy[0];
    assign rdyf     = !vldf_reg || out_ready;
    assign in_ready = rdyp;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        dv_t           src;
        dv_t           nxt;
        logic          src_vld;
        logic [DW:0]   t1;
        logic [DW:0]   t2;
        logic          b1;
        logic          b2;

        if (k == 0)
        begin : g_first
            assign src     = prep_reg;
            assign src_vld = vldp_reg;
        end
        else
        begin : g_rest
            assign src     = stg_reg[k-1];
            assign src_vld = vld_reg[k-1];
        end

        if (k == N-1)
        begin : g_last
            assign rdy[k] = !vld_reg[k] || rdyf;
        end
        else
        begin : g_mid
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end

        always_comb
        begin
            t1  = {src.rem1, src.dq1[QW-1]};
            t2  = {src.rem2, src.dq2[QW-1]};
            b1  = (t1 >= {1'b0, src.den});
            b2  = (t2 >= {1'b0, src.den});
            nxt = src;
            nxt.rem1 = b1 ? DW'(t1 - {1'b0, src.den}) : t1[DW-1:0];
            nxt.rem2 = b2 ? DW'(t2 - {1'b0, src.den}) : t2[DW-1:0];
            nxt.dq1  = {src.dq1[QW-2:0], b1};
            nxt.dq2  = {src.dq2[QW-2:0], b2};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_vld)
            begin
                stg_reg[k] <= nxt;
            end
        end
    end

    logic [QW-1:0] s1;
    logic [QW-1:0] s2;

    always_comb
    begin
        s1 = sat_q(stg_reg[N-1].dq1, stg_reg[N-1].neg1);
        s2 = sat_q(stg_reg[N-1].dq2, stg_reg[N-1].neg2);
        res_next.kind = stg_reg[N-1].kind;
        if (stg_reg[N-1].kind == qrs_pkg::KIND_DEGEN)
        begin
            res_next.first  = '0;
            res_next.second = '0;
            res_next.ovf    = 1'b0;
        end
        else
        begin
            res_next.first  = s1[31:0];
            res_next.second = s2[31:0];
            res_next.ovf    = s1[QW-1] | s2[QW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldp_reg <= 1'b0;
            vldf_reg <= 1'b0;
        end
        else
        begin
            if (rdyp)
            begin
                vldp_reg <= in_valid;
            end
            if (rdyf)
            begin
                vldf_reg <= vld_reg[N-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdyp && in_valid)
        begin
            prep_reg <= prep_next;
        end
        if (rdyf && vld_reg[N-1])
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = vldf_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

// ===== bench/quadratic_root_solver_tb.sv =====
// Self-checking stream testbench for the quadratic root solver.
`timescale 1ns / 1ps

module quadratic_root_solver_tb;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] first;
        logic [31:0] second;
        logic        ovf;
    } roots_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [47:0] coef_queue[$];
    roots_t      roots_expected[$];
    int          errors;
    int          sent;
    int          received;
    int          idle_cycles;
    int          src_gap;
    int          snk_gap;
    bit          calm;
    bit          hold_src;
    bit          stim_done;

    quadratic_root_solver dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [31:0] sat_quot(longint num, longint den, ref logic ovf);
        longint q;
        q = (num * 128) / den;
        if (q > 64'sd2147483647)
        begin
            ovf = 1'b1;
            q = 64'sd2147483647;
        end
        else if (q < -64'sd2147483648)
        begin
            ovf = 1'b1;
            q = -64'sd2147483648;
        end
        return q[31:0];
    endfunction

    function automatic roots_t solve_roots(logic [47:0] coefs);
        roots_t          res;
        longint          a;
        longint          b;
        longint          c;
        longint          d;
        longint          s;
        longint          nb;
        longint unsigned mag;
        logic            ovf;
        a = longint'($signed(coefs[15:0]));
        b = longint'($signed(coefs[31:16]));
        c = longint'($signed(coefs[47:32]));
        ovf = 1'b0;
        res.first = '0;
        res.second = '0;
        if (a == 0)
            res.kind = qrs_pkg::KIND_DEGEN;
        else
        begin
            d = b * b - 4 * a * c;
            mag = (d < 0) ? longint'(-d) : d;
            s = isqrt(mag << 16);
            nb = -b * 256;
            if (d > 0)
            begin
                res.kind = qrs_pkg::KIND_REAL;
                res.first = sat_quot(nb + s, a, ovf);
                res.second = sat_quot(nb - s, a, ovf);
            end
            else if (d == 0)
            begin
                res.kind = qrs_pkg::KIND_DOUBLE;
                res.first = sat_quot(nb, a, ovf);
                res.second = res.first;
            end
            else
            begin
                res.kind = qrs_pkg::KIND_COMPLEX;
                res.first = sat_quot(nb, a, ovf);
                res.second = sat_quot(s, (a < 0) ? -a : a, ovf);
            end
        end
        res.ovf = ovf;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s at result %0d: got %h want %h", what, received, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            src_gap <= 0;
            sent <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                roots_expected.push_back(solve_roots(s_tdata));
                sent <= sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    src_gap <= $urandom_range(0, 15);
                    s_tvalid <= 1'b0;
                end
                else if (!hold_src && coef_queue.size() > 0)
                begin
                    s_tdata <= coef_queue.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        roots_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap <= 0;
            received <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (roots_expected.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
                else
                begin
                    want = roots_expected.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("root_kind", m_tuser, want.kind);
                    if (m_tdata[31:0] !== want.first)
                        report_mismatch("first_value", m_tdata[31:0], want.first);
                    if (m_tdata[63:32] !== want.second)
                        report_mismatch("second_value", m_tdata[63:32], want.second);
                    if (m_tdata[64] !== want.ovf)
                        report_mismatch("overflow", m_tdata[64], want.ovf);
                    if (m_tdata[71:65] !== 7'd0)
                        report_mismatch("fill", m_tdata[71:65], 0);
                end
                received <= received + 1;
            end
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                snk_gap <= $urandom_range(0, 15);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            3: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] a;
        logic [15:0] b;
        errors = 0;
        calm = 1'b0;
        hold_src = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        coef_queue.push_back({16'h0100, 16'h0000, 16'h0000});
        coef_queue.push_back({16'h0100, 16'h0100, 16'h0000});
        coef_queue.push_back({16'h0100, 16'h0200, 16'h0100});
        coef_queue.push_back({16'h0100, 16'h0000, 16'h0100});
        coef_queue.push_back({16'h0100, 16'hFD00, 16'h0100});
        coef_queue.push_back({16'h7FFF, 16'h7FFF, 16'h0000});
        coef_queue.push_back({16'h8000, 16'h8000, 16'h8000});
        coef_queue.push_back({16'h7FFF, 16'h8000, 16'h8000});
        coef_queue.push_back({16'h8000, 16'h7FFF, 16'h7FFF});
        coef_queue.push_back({16'h0001, 16'h8000, 16'h0001});
        coef_queue.push_back({16'hFFFF, 16'h7FFF, 16'hFFFF});
        coef_queue.push_back({16'h7FFF, 16'h0000, 16'h0001});
        coef_queue.push_back({16'hFFFF, 16'hFFFF, 16'h0000});
        coef_queue.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
        coef_queue.push_back({16'h0100, 16'h0400, 16'hFF00});
        coef_queue.push_back({16'h0400, 16'h0400, 16'h0100});
        coef_queue.push_back({16'h0001, 16'h0002, 16'h0001});

        for (int i = 0; i < 800; i++)
        begin
            if (i == 400)
            begin
                wait (coef_queue.size() == 0);
                hold_src = 1'b1;
                wait (roots_expected.size() == 0 && !s_tvalid);
                hold_src = 1'b0;
            end
            if (i == 700)
            begin
                wait (coef_queue.size() == 0);
                calm = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                a = 16'(16'($urandom_range(1, 64)) << $urandom_range(0, 8));
                b = 16'(a << 1);
                coef_queue.push_back({16'(a >> 1), b, a});
            end
            else
                coef_queue.push_back({pick_coef(), pick_coef(), pick_coef()});
        end

        wait (coef_queue.size() == 0 && !s_tvalid);
        wait (roots_expected.size() == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d coefficient sets: all root kinds, extremes, saturation", sent);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_front.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver.sv
bench/quadratic_root_solver_tb.sv
